[design/kmd_pkg.sv]
// Shared types and constants for the key matrix debounce and event reporter.
package kmd_pkg;

    localparam int KEYS = 12;
    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CNT_W = $clog2(KEYS + 1);
    localparam int IDX_W = 4;
    localparam int TIME_W = 32;
    localparam int DELAY_W = 16;
    localparam int CODE_W = 8;
    localparam logic [DELAY_W-1:0] DEFAULT_DEBOUNCE = 16'd10;

    typedef enum logic [2:0] {
        OP_SAMPLE    = 3'd0,
        OP_MAP_BEGIN = 3'd1,
        OP_MAP_BYTE  = 3'd2,
        OP_MAP_END   = 3'd3,
        OP_HOST_READ = 3'd4
    } op_t;

    typedef struct packed {
        logic              en;
        logic [KEY_W-1:0]  idx;
        logic              lvl;
        logic [TIME_W-1:0] now;
    } sample_req_t;

    typedef struct packed {
        logic changed;
        logic stable;
    } sample_rsp_t;

endpackage

[design/key_matrix_debounce_event_reporter.sv]
// Top level of the key matrix debounce and event reporter.
// A word accepted into the input register has its result written to the result register.
// One word per cycle unless out_ready stalls; input and result registers each hold one.
// The key state update and the event latch both happen in the work stage.
// Reset (rst_n, asynchronous, active low) releases all keys, zeroes timers and event,
// clears the keymap count and loaded flag, asserts the interrupt and sets the delay to 10.
module key_matrix_debounce_event_reporter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [kmd_pkg::DELAY_W-1:0]       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        op,
    input  logic [kmd_pkg::IDX_W-1:0]         key_index,
    input  logic                              level,
    input  logic [kmd_pkg::TIME_W-1:0]        now_ms,
    input  logic [kmd_pkg::CODE_W-1:0]        map_code,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              irq_line,
    output logic [kmd_pkg::CODE_W-1:0]        read_code,
    output logic                              read_state,
    output logic                              key_stable
);

    logic [kmd_pkg::DELAY_W-1:0] delay_reg;

    logic                        in_valid_reg;
    logic [2:0]                  op_reg;
    logic [kmd_pkg::IDX_W-1:0]   key_index_reg;
    logic                        level_reg;
    logic [kmd_pkg::TIME_W-1:0]  now_ms_reg;
    logic [kmd_pkg::CODE_W-1:0]  map_code_reg;

    logic [kmd_pkg::CODE_W-1:0]  keymap_reg [kmd_pkg::KEYS];
    logic [kmd_pkg::CNT_W-1:0]   keymap_count_reg;
    logic [kmd_pkg::CNT_W-1:0]   keymap_count_next;
    logic                        keymap_loaded_reg;
    logic                        keymap_loaded_next;
    logic [kmd_pkg::CODE_W-1:0]  event_code_reg;
    logic [kmd_pkg::CODE_W-1:0]  event_code_next;
    logic                        event_pressed_reg;
    logic                        event_pressed_next;
    logic                        irq_level_reg;
    logic                        irq_level_next;

    logic                        out_valid_reg;
    logic                        irq_line_reg;
    logic [kmd_pkg::CODE_W-1:0]  read_code_reg;
    logic                        read_state_reg;
    logic                        key_stable_reg;
    logic [kmd_pkg::CODE_W-1:0]  read_code_next;
    logic                        read_state_next;
    logic                        key_stable_next;

    logic                        work_fire;
    logic                        idx_ok;
    logic                        map_write;
    kmd_pkg::op_t                op_code;
    kmd_pkg::sample_req_t        bank_req;
    kmd_pkg::sample_rsp_t        bank_rsp;

    assign work_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || work_fire;
    assign op_code   = kmd_pkg::op_t'(op_reg);
    assign idx_ok    = (32'(key_index_reg) < kmd_pkg::KEYS);

    assign bank_req.en  = work_fire && (op_code == kmd_pkg::OP_SAMPLE) && idx_ok;
    assign bank_req.idx = key_index_reg[kmd_pkg::KEY_W-1:0];
    assign bank_req.lvl = level_reg;
    assign bank_req.now = now_ms_reg;

    kmd_key_bank u_key_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .delay (delay_reg),
        .req   (bank_req),
        .rsp   (bank_rsp)
    );

    always_comb
    begin
        keymap_count_next  = keymap_count_reg;
        keymap_loaded_next = keymap_loaded_reg;
        event_code_next    = event_code_reg;
        event_pressed_next = event_pressed_reg;
        irq_level_next     = irq_level_reg;
        read_code_next     = '0;
        read_state_next    = 1'b0;
        key_stable_next    = 1'b1;
        map_write          = 1'b0;
        unique case (op_code)
            kmd_pkg::OP_SAMPLE:
            begin
                if (idx_ok)
                begin
                    key_stable_next = bank_rsp.stable;
                    if (bank_rsp.changed && keymap_loaded_reg
                        && (32'(key_index_reg) < 32'(keymap_count_reg)))
                    begin
                        event_code_next    = keymap_reg[key_index_reg[kmd_pkg::KEY_W-1:0]];
                        event_pressed_next = !level_reg;
                        irq_level_next     = 1'b0;
                    end
                end
            end
            kmd_pkg::OP_MAP_BEGIN:
            begin
                keymap_count_next = '0;
            end
            kmd_pkg::OP_MAP_BYTE:
            begin
                if (32'(keymap_count_reg) < kmd_pkg::KEYS)
                begin
                    map_write         = 1'b1;
                    keymap_count_next = keymap_count_reg + 1'b1;
                end
            end
            kmd_pkg::OP_MAP_END:
            begin
                keymap_loaded_next = 1'b1;
                irq_level_next     = 1'b1;
            end
            kmd_pkg::OP_HOST_READ:
            begin
                read_code_next     = event_code_reg;
                read_state_next    = event_pressed_reg;
                event_code_next    = '0;
                event_pressed_next = 1'b0;
                irq_level_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg         <= kmd_pkg::DEFAULT_DEBOUNCE;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            keymap_count_reg  <= '0;
            keymap_loaded_reg <= 1'b0;
            event_code_reg    <= '0;
            event_pressed_reg <= 1'b0;
            irq_level_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (work_fire)
            begin
                out_valid_reg     <= 1'b1;
                keymap_count_reg  <= keymap_count_next;
                keymap_loaded_reg <= keymap_loaded_next;
                event_code_reg    <= event_code_next;
                event_pressed_reg <= event_pressed_next;
                irq_level_reg     <= irq_level_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg        <= op;
            key_index_reg <= key_index;
            level_reg     <= level;
            now_ms_reg    <= now_ms;
            map_code_reg  <= map_code;
        end
        if (work_fire)
        begin
            irq_line_reg   <= irq_level_next;
            read_code_reg  <= read_code_next;
            read_state_reg <= read_state_next;
            key_stable_reg <= key_stable_next;
        end
        if (work_fire && map_write)
        begin
            keymap_reg[keymap_count_reg[kmd_pkg::KEY_W-1:0]] <= map_code_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign irq_line   = irq_line_reg;
    assign read_code  = read_code_reg;
    assign read_state = read_state_reg;
    assign key_stable = key_stable_reg;

`ifndef ASSERT_OFF
    a_read_releases_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (work_fire && (op_code == kmd_pkg::OP_HOST_READ)) |=> (irq_level_reg && !event_pressed_reg))
        else $error("host read did not release the interrupt and clear the event");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        work_fire |=> (32'(keymap_count_reg) <= kmd_pkg::KEYS))
        else $error("keymap count ran past the number of keys");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled while a stage was free");

    a_result_matches_irq: assert property (@(posedge clk) disable iff (!rst_n)
        work_fire |=> (irq_line_reg == irq_level_reg))
        else $error("reported interrupt line differs from the interrupt state");
`endif

endmodule

[design/kmd_key_bank.sv]
// Per-key debounce state: previous level, stable level and last change time.
module kmd_key_bank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kmd_pkg::DELAY_W-1:0]   delay,
    input  kmd_pkg::sample_req_t          req,
    output kmd_pkg::sample_rsp_t          rsp
);

    logic [kmd_pkg::KEYS-1:0]   prev_reg;
    logic [kmd_pkg::KEYS-1:0]   stable_reg;
    logic [kmd_pkg::TIME_W-1:0] last_reg [kmd_pkg::KEYS];

    logic                       prev_lvl;
    logic                       stable_lvl;
    logic [kmd_pkg::TIME_W-1:0] elapsed;
    logic                       level_held;
    logic                       change;

    always_comb
    begin
        prev_lvl   = prev_reg[req.idx];
        stable_lvl = stable_reg[req.idx];
        elapsed    = req.now - last_reg[req.idx];
        level_held = (req.lvl == prev_lvl);
        change     = level_held
                     && (elapsed > {{(kmd_pkg::TIME_W - kmd_pkg::DELAY_W){1'b0}}, delay})
                     && (req.lvl != stable_lvl);
        rsp.changed = req.en && change;
        rsp.stable  = change ? req.lvl : stable_lvl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '1;
            stable_reg <= '1;
            for (int i = 0; i < kmd_pkg::KEYS; i++)
            begin
                last_reg[i] <= '0;
            end
        end
        else if (req.en)
        begin
            prev_reg[req.idx] <= req.lvl;
            if (!level_held)
            begin
                last_reg[req.idx] <= req.now;
            end
            if (change)
            begin
                stable_reg[req.idx] <= req.lvl;
            end
        end
    end

endmodule
